[rtl/core/assert_macros.svh]
// assertion macros for the checker file
// no dependencies; clock and reset are taken from the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent property on the rising edge of clk, off while reset is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// overlapped implication on the same clock and reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

[rtl/core/utf8d_pkg.sv]
// types and constants shared by the utf-8 decoder modules
// no dependencies
package utf8d_pkg;

	// scan window: up to three buffered bytes plus the new byte
	localparam int WinDepth = 4;
	localparam int CountBits = $clog2(WinDepth + 1);
	localparam int IdxBits = $clog2(WinDepth);

	typedef logic [7:0] byte_t;
	typedef logic [WinDepth-1:0][7:0] win_t;
	typedef logic [CountBits-1:0] count_t;
	typedef logic [IdxBits-1:0] idx_t;

	// lead byte boundaries and continuation pattern
	localparam byte_t Lead2Min = 8'hC0;
	localparam byte_t Lead3Min = 8'hE0;
	localparam byte_t Lead4Min = 8'hF0;
	localparam byte_t LeadBadMin = 8'hF8;
	localparam byte_t ContMask = 8'hC0;
	localparam byte_t ContTag = 8'h80;

	// one decoded result
	typedef struct packed {
		logic [20:0] code_point;
		logic [2:0] byte_count;
		logic is_fallback;
		logic run_last;
		logic stream_last;
	} result_t;

	// scan status toward the control logic
	typedef struct packed {
		logic emit;
		logic done;
	} scan_ctl_t;

endpackage

[rtl/core/utf8_decoder_latin1_fallback.sv]
// top level of the streaming utf-8 decoder with latin-1 fallback
// depends on utf8d_pkg, utf8d_scan, utf8d_out_stage
//
//   channel  fields                                         handshake
//   byte     data_byte, end_of_stream                       byte_valid / byte_stall
//   result   code_point, byte_count, is_fallback,           result_valid / result_stall
//            run_last, stream_last
//
// a byte transfer loads the window register; the scan unit gives one result per
// cycle into the result register while it is free, so a byte that causes k results
// (0 to 4) keeps byte_stall high until its last one; bytes with at most one result
// flow one per cycle while the result register is free. the first result of a byte
// is valid after the window register and then the result register, and the next
// byte is taken in the cycle the last result of the current one is produced.
// reset empties the pending buffer; result_stall holds the result register and,
// once the window has a result to give, raises byte_stall.
module utf8_decoder_latin1_fallback (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_stall,
	input logic [7:0] data_byte,
	input logic end_of_stream,
	output logic result_valid,
	input logic result_stall,
	output logic [20:0] code_point,
	output logic [2:0] byte_count,
	output logic is_fallback,
	output logic run_last,
	output logic stream_last
);
	import utf8d_pkg::*;

	win_t win_s1;
	count_t cnt_s1;
	logic eos_s1;
	logic act_s1;

	scan_ctl_t ctl;
	result_t res;
	win_t rest_bytes;
	count_t rest_cnt;
	logic out_free;
	logic fire;
	logic finish;
	logic byte_xfer;
	win_t base_bytes;
	count_t base_cnt;
	win_t next_bytes;

	utf8d_scan u_scan (
		.win_bytes(win_s1),
		.win_cnt(cnt_s1),
		.eos(eos_s1),
		.ctl(ctl),
		.res(res),
		.rest_bytes(rest_bytes),
		.rest_cnt(rest_cnt)
	);

	utf8d_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(fire && ctl.emit),
		.res(res),
		.result_stall(result_stall),
		.free(out_free),
		.result_valid(result_valid),
		.code_point(code_point),
		.byte_count(byte_count),
		.is_fallback(is_fallback),
		.run_last(run_last),
		.stream_last(stream_last)
	);

	// step control: a step runs when it gives no result or the result register is free
	assign fire = act_s1 && (!ctl.emit || out_free);
	assign finish = fire && ctl.done;
	assign byte_stall = act_s1 && !finish;
	assign byte_xfer = byte_valid && !byte_stall;

	// append the new byte after what remains buffered
	always_comb begin
		base_bytes = act_s1 ? rest_bytes : win_s1;
		base_cnt = act_s1 ? rest_cnt : cnt_s1;
		next_bytes = base_bytes;
		next_bytes[idx_t'(base_cnt)] = data_byte;
	end

	// window control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= '0;
			eos_s1 <= 1'b0;
			act_s1 <= 1'b0;
		end else if (byte_xfer) begin
			cnt_s1 <= base_cnt + count_t'(1);
			eos_s1 <= end_of_stream;
			act_s1 <= 1'b1;
		end else if (fire) begin
			cnt_s1 <= rest_cnt;
			if (finish) begin
				act_s1 <= 1'b0;
			end
		end
	end

	// window bytes
	always_ff @(posedge clk) begin
		if (byte_xfer) begin
			win_s1 <= next_bytes;
		end else if (fire) begin
			win_s1 <= rest_bytes;
		end
	end

endmodule

[rtl/core/utf8d_scan.sv]
// one scan step over the byte window: decodes or falls back on the lead byte,
// shifts out the consumed bytes and looks ahead to tell the last result
// depends on utf8d_pkg
module utf8d_scan (
	input utf8d_pkg::win_t win_bytes,
	input utf8d_pkg::count_t win_cnt,
	input logic eos,
	output utf8d_pkg::scan_ctl_t ctl,
	output utf8d_pkg::result_t res,
	output utf8d_pkg::win_t rest_bytes,
	output utf8d_pkg::count_t rest_cnt
);
	import utf8d_pkg::*;

	// sequence length a lead byte calls for
	function automatic count_t lead_len(input byte_t c);
		if (c < Lead2Min || c >= LeadBadMin) begin
			return count_t'(1);
		end else if (c < Lead3Min) begin
			return count_t'(2);
		end else if (c < Lead4Min) begin
			return count_t'(3);
		end
		return count_t'(4);
	endfunction

	function automatic logic is_cont(input byte_t b);
		return (b & ContMask) == ContTag;
	endfunction

	// true when the window is a valid but unfinished sequence to keep buffered
	function automatic logic waits(input win_t w, input count_t n, input logic e);
		count_t l;
		logic ok;
		l = lead_len(w[0]);
		ok = 1'b1;
		for (int i = 1; i < WinDepth; i++) begin
			if ((count_t'(i) < n) && !is_cont(w[i])) begin
				ok = 1'b0;
			end
		end
		return (n != '0) && (n < l) && ok && !e;
	endfunction

	count_t len;
	count_t take;
	logic bad;
	logic complete;
	logic hold;
	win_t shifted;

	always_comb begin
		len = lead_len(win_bytes[0]);

		// any byte inside the sequence that is not a continuation
		bad = 1'b0;
		for (int i = 1; i < WinDepth; i++) begin
			if ((count_t'(i) < win_cnt) && (count_t'(i) < len) && !is_cont(win_bytes[i])) begin
				bad = 1'b1;
			end
		end
		complete = (len > count_t'(1)) && !bad && (win_cnt >= len);
		hold = (len > count_t'(1)) && !bad && (win_cnt < len) && !eos;
		take = complete ? len : count_t'(1);

		// assemble the code point, or pass the lead through
		res.code_point = {13'd0, win_bytes[0]};
		if (complete) begin
			unique case (len)
				count_t'(2): res.code_point = {10'd0, win_bytes[0][4:0], win_bytes[1][5:0]};
				count_t'(3): res.code_point = {5'd0, win_bytes[0][3:0], win_bytes[1][5:0],
					win_bytes[2][5:0]};
				default: res.code_point = {win_bytes[0][2:0], win_bytes[1][5:0],
					win_bytes[2][5:0], win_bytes[3][5:0]};
			endcase
		end
		res.byte_count = take;
		res.is_fallback = !complete && win_bytes[0][7];

		// drop the consumed bytes
		unique case (take)
			count_t'(1): shifted = {8'd0, win_bytes[3:1]};
			count_t'(2): shifted = {16'd0, win_bytes[3:2]};
			count_t'(3): shifted = {24'd0, win_bytes[3]};
			default: shifted = '0;
		endcase

		if (hold) begin
			rest_bytes = win_bytes;
			rest_cnt = win_cnt;
		end else begin
			rest_bytes = shifted;
			rest_cnt = win_cnt - take;
		end

		// last result of this byte when nothing or only a waiting sequence remains
		ctl.emit = !hold;
		ctl.done = hold || (rest_cnt == '0) || waits(rest_bytes, rest_cnt, eos);
		res.run_last = ctl.done;
		res.stream_last = ctl.done && eos;
	end

endmodule

[rtl/core/utf8d_out_stage.sv]
// result register with valid and stall toward the consumer
// depends on utf8d_pkg
module utf8d_out_stage (
	input logic clk,
	input logic arst_n,
	input logic load,
	input utf8d_pkg::result_t res,
	input logic result_stall,
	output logic free,
	output logic result_valid,
	output logic [20:0] code_point,
	output logic [2:0] byte_count,
	output logic is_fallback,
	output logic run_last,
	output logic stream_last
);
	import utf8d_pkg::*;

	logic valid_s2;
	result_t res_s2;

	// register may take a new result when empty or being drained
	assign free = !valid_s2 || !result_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign code_point = res_s2.code_point;
	assign byte_count = res_s2.byte_count;
	assign is_fallback = res_s2.is_fallback;
	assign run_last = res_s2.run_last;
	assign stream_last = res_s2.stream_last;

endmodule

[rtl/core/utf8d_checker.sv]
// port-level checks on the utf-8 decoder results, bound to the top level
// depends on assert_macros.svh and utf8_decoder_latin1_fallback
`include "assert_macros.svh"

module utf8d_checker (
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_stall,
	input logic [20:0] code_point,
	input logic [2:0] byte_count,
	input logic is_fallback,
	input logic run_last,
	input logic stream_last
);

	// a stalled result holds until its transfer
	`ASSERT_CLK(a_result_hold, (result_valid && result_stall) |=> (result_valid && $stable(code_point) && $stable(byte_count) && $stable(run_last)), "stalled result changed")

	// a single byte result is the byte itself, fallback exactly when its top bit is set
	`ASSERT_IMPL(a_single_byte, result_valid && (byte_count == 3'd1), (code_point[20:8] == 13'd0) && (code_point[7] == is_fallback), "single byte result malformed")

	// fallback results always consume one byte
	`ASSERT_IMPL(a_fallback_len, result_valid && is_fallback, byte_count == 3'd1, "fallback with multibyte count")

	// end of stream result closes its byte run
	`ASSERT_IMPL(a_stream_run, result_valid && stream_last, run_last, "stream_last without run_last")

endmodule

bind utf8_decoder_latin1_fallback utf8d_checker u_checker (.*);

[bench/utf8_decoder_latin1_fallback_test.sv]
// self-checking bench for utf8_decoder_latin1_fallback: directed and random byte streams
// a code point predictor runs next to the block and each result transfer is compared with it
// depends on utf8d_pkg and the utf8_decoder_latin1_fallback top level
module utf8_decoder_latin1_fallback_test;
	import utf8d_pkg::*;

	logic clk;
	logic arst_n;
	logic byte_valid;
	logic byte_stall;
	logic [7:0] data_byte;
	logic end_of_stream;
	logic result_valid;
	logic result_stall;
	logic [20:0] code_point;
	logic [2:0] byte_count;
	logic is_fallback;
	logic run_last;
	logic stream_last;

	// predictor state: bytes held back while a sequence is incomplete
	byte_t held_bytes [3];
	int unsigned held_count;
	result_t expected_code_points [$];

	logic idle_on;
	int unsigned fail_count;
	int unsigned bytes_sent;
	int unsigned results_checked;
	int unsigned fallback_count;
	int unsigned streams_closed;

	utf8_decoder_latin1_fallback u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.code_point(code_point),
		.byte_count(byte_count),
		.is_fallback(is_fallback),
		.run_last(run_last),
		.stream_last(stream_last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard limit on run length
	initial begin
		#400000;
		$display("[utf8_decoder_latin1_fallback] ERROR");
		$finish;
	end

	// sequence length a lead byte calls for; 1 for ascii, continuations and f8-ff
	function automatic int unsigned lead_span(byte_t c);
		if (c < Lead2Min || c >= LeadBadMin)
			return 1;
		if (c < Lead3Min)
			return 2;
		if (c < Lead4Min)
			return 3;
		return 4;
	endfunction

	// work out the code points one accepted byte gives and queue them
	function automatic void predict_code_points(byte_t b, logic eos);
		byte_t win [4];
		int unsigned n, span, take, i;
		logic [20:0] cp;
		logic fb, broken;
		result_t r;
		result_t found [$];
		for (i = 0; i < held_count; i++)
			win[i] = held_bytes[i];
		win[held_count] = b;
		n = held_count + 1;
		while (n > 0) begin
			span = lead_span(win[0]);
			take = 1;
			cp = {13'd0, win[0]};
			fb = win[0][7];
			if (span > 1) begin
				broken = 1'b0;
				for (i = 1; i < n && i < span; i++)
					if ((win[i] & ContMask) != ContTag)
						broken = 1'b1;
				if (!broken && n >= span) begin
					case (span)
						2: cp = {10'd0, win[0][4:0], win[1][5:0]};
						3: cp = {5'd0, win[0][3:0], win[1][5:0], win[2][5:0]};
						default: cp = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
					endcase
					take = span;
					fb = 1'b0;
				end else if (!broken && !eos) begin
					break;
				end
			end
			r.code_point = cp;
			r.byte_count = 3'(take);
			r.is_fallback = fb;
			r.run_last = 1'b0;
			r.stream_last = 1'b0;
			found = {found, r};
			// drop the consumed bytes and rescan what is left
			for (i = 0; i + take < n; i++)
				win[i] = win[i + take];
			n -= take;
		end
		for (i = 0; i < n; i++)
			held_bytes[i] = win[i];
		held_count = n;
		foreach (found[j]) begin
			r = found[j];
			r.run_last = (j == found.size() - 1);
			r.stream_last = r.run_last && eos;
			expected_code_points = {expected_code_points, r};
		end
	endfunction

	// one byte transfer, with a random gap in front of it
	task automatic send_byte(input byte_t b, input logic eos);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 33) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		do
			@(posedge clk);
		while (byte_stall !== 1'b0);
		predict_code_points(b, eos);
		bytes_sent++;
		if (eos)
			streams_closed++;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s expected %0h actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	// result side: random stall at the falling edge
	initial begin
		forever begin
			@(negedge clk);
			result_stall <= idle_on && ($urandom_range(0, 99) < 33);
		end
	end

	// result side: compare each result transfer with the oldest prediction
	initial begin
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
				if (expected_code_points.size() == 0) begin
					$error("unexpected result code_point %0h", code_point);
					fail_count++;
				end else begin
					want = expected_code_points.pop_front();
					check_field("code_point", want.code_point, code_point);
					check_field("byte_count", want.byte_count, byte_count);
					check_field("is_fallback", want.is_fallback, is_fallback);
					check_field("run_last", want.run_last, run_last);
					check_field("stream_last", want.stream_last, stream_last);
					results_checked++;
					if (want.is_fallback)
						fallback_count++;
				end
			end
		end
	end

	// ascii extremes, lone continuations and the never-valid leads
	task automatic test_single_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hF8, 1'b0);
		send_byte(8'hFF, 1'b0);
	endtask

	// complete 2-, 3- and 4-byte sequences at their extremes
	task automatic test_full_sequences();
		send_byte(8'hC0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hF7, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
	endtask

	// broken sequences: lead falls back and the rest is rescanned
	task automatic test_broken_sequences();
		// three held bytes released by ascii: four results from one byte
		send_byte(8'hF0, 1'b0);
		send_byte(8'h90, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h41, 1'b0);
		// lead cut off by a new lead that then completes
		send_byte(8'hE2, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'hA9, 1'b0);
	endtask

	// end of stream flushes an incomplete sequence
	task automatic test_end_flush();
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b1);
		send_byte(8'hF5, 1'b1);
	endtask

	// mostly well-formed sequences with random content, some noise and cuts
	task automatic send_random_stream(input int unsigned n_items);
		int unsigned sent, span, j;
		byte_t b;
		logic eos;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 15) begin
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
				sent++;
			end else begin
				span = $urandom_range(1, 4);
				for (j = 0; j < span; j++) begin
					if (j == 0) begin
						case (span)
							1: b = 8'($urandom_range(8'h00, 8'h7F));
							2: b = 8'($urandom_range(Lead2Min, Lead3Min - 1));
							3: b = 8'($urandom_range(Lead3Min, Lead4Min - 1));
							default: b = 8'($urandom_range(Lead4Min, LeadBadMin - 1));
						endcase
					end else if ($urandom_range(0, 29) == 0) begin
						b = 8'($urandom_range(0, 255));
					end else begin
						b = {2'b10, 6'($urandom)};
					end
					if (j == span - 1)
						eos = ($urandom_range(0, 14) == 0);
					else
						eos = ($urandom_range(0, 39) == 0);
					send_byte(b, eos);
					sent++;
				end
			end
		end
	endtask

	task automatic test_random_stream();
		send_random_stream(45);
	endtask

	// back-to-back transfers on both sides
	task automatic test_steady_stream();
		idle_on = 1'b0;
		send_random_stream(30);
		idle_on = 1'b1;
	endtask

	// reset, tests in turn, drain and verdict
	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		data_byte = 8'h00;
		end_of_stream = 1'b0;
		result_stall = 1'b0;
		idle_on = 1'b1;
		held_count = 0;
		fail_count = 0;
		bytes_sent = 0;
		results_checked = 0;
		fallback_count = 0;
		streams_closed = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_single_bytes();
		test_full_sequences();
		test_broken_sequences();
		test_end_flush();
		test_random_stream();
		test_steady_stream();

		@(negedge clk);
		byte_valid <= 1'b0;
		wait (expected_code_points.size() == 0);
		repeat (8) @(posedge clk);
		if (expected_code_points.size() != 0) begin
			$error("%0d predicted results never arrived", expected_code_points.size());
			fail_count++;
		end

		$display("sent %0d bytes in %0d closed streams, checked %0d results, %0d latin-1",
			bytes_sent, streams_closed, results_checked, fallback_count);
		if (fail_count == 0)
			$display("[utf8_decoder_latin1_fallback] OK");
		else
			$display("[utf8_decoder_latin1_fallback] ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_scan.sv
rtl/core/utf8d_out_stage.sv
rtl/core/utf8_decoder_latin1_fallback.sv
rtl/core/utf8d_checker.sv
bench/utf8_decoder_latin1_fallback_test.sv
